// ===== design/msls_pkg.sv =====
// Shared types, codes and constants for the motor safety level supervisor.
// No dependencies; used by msls_next and motor_safety_level_supervisor.
`timescale 1ns / 1ps
`default_nettype none

package msls_pkg;

  localparam int WAIT_COUNT_BITS_DEFAULT = 20;
  localparam int WAIT_RESET_TICKS = 5000;

  // Safety levels, one-hot.
  typedef enum logic [6:0] {
    LV_OFF       = 7'b0000001,
    LV_EMERGENCY = 7'b0000010,
    LV_ON        = 7'b0000100,
    LV_STARTING  = 7'b0001000,
    LV_STOPPING  = 7'b0010000,
    LV_POWER_ON  = 7'b0100000,
    LV_MOVING    = 7'b1000000
  } level_t;

  // Level codes as they appear on the result stream.
  localparam logic [2:0] LVC_OFF       = 3'd0;
  localparam logic [2:0] LVC_EMERGENCY = 3'd1;
  localparam logic [2:0] LVC_ON        = 3'd2;
  localparam logic [2:0] LVC_STARTING  = 3'd3;
  localparam logic [2:0] LVC_STOPPING  = 3'd4;
  localparam logic [2:0] LVC_POWER_ON  = 3'd5;
  localparam logic [2:0] LVC_MOVING    = 3'd6;

  // Command codes carried with each tick.
  localparam logic [2:0] CMD_NONE            = 3'd0;
  localparam logic [2:0] CMD_SWITCH_ON       = 3'd1;
  localparam logic [2:0] CMD_SWITCH_OFF      = 3'd2;
  localparam logic [2:0] CMD_STOP_MOVING     = 3'd3;
  localparam logic [2:0] CMD_ABORT           = 3'd4;
  localparam logic [2:0] CMD_FORCE_EMERGENCY = 3'd5;

  typedef struct packed {
    level_t level;
    logic   running;
  } state_t;

  typedef struct packed {
    state_t state;
    logic   drive_enable;
  } step_t;

  function automatic logic [2:0] level_code(level_t lv);
    logic [2:0] code;
    unique case (lv)
      LV_OFF:       code = LVC_OFF;
      LV_EMERGENCY: code = LVC_EMERGENCY;
      LV_ON:        code = LVC_ON;
      LV_STARTING:  code = LVC_STARTING;
      LV_STOPPING:  code = LVC_STOPPING;
      LV_POWER_ON:  code = LVC_POWER_ON;
      LV_MOVING:    code = LVC_MOVING;
      default:      code = LVC_OFF;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== design/motor_safety_level_supervisor.sv =====
// Motor safety level supervisor: input register, next-state logic, result register.
// Depends on msls_pkg and msls_next.
//
//  channel   | direction | fields (lowest bit up)
//  s_axis    | in        | tdata: emergency_in, drive_ready; tuser: kind
//  m_axis    | out       | tdata: drive_enable, level_now[2:0], control_active
//  cfg_wr    | in        | start_wait_ticks
//
// One tick per cycle while the result is not stalled; input register, then result register.
// The level update sits between the input register and the result register.
// Reset: level off, counter and run flag cleared, start_wait_ticks = 5000 (truncated).
// A stalled result holds the result register; the input register refills behind it
// and then holds until the result moves.
`timescale 1ns / 1ps
`default_nettype none

module motor_safety_level_supervisor #(
  parameter int WAIT_COUNT_BITS = msls_pkg::WAIT_COUNT_BITS_DEFAULT
) (
  input  var logic                       clk,
  input  var logic                       rst,
  input  var logic                       s_axis_tvalid,
  output logic                           s_axis_tready,
  input  var logic [7:0]                 s_axis_tdata,  // emergency_in, drive_ready, pad
  input  var logic [2:0]                 s_axis_tuser,  // kind
  output logic                           m_axis_tvalid,
  input  var logic                       m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // drive_enable, level_now, control_active, pad
  input  var logic                       cfg_wr_en,
  input  var logic [WAIT_COUNT_BITS-1:0] cfg_wr_data
);

  localparam int CW = WAIT_COUNT_BITS + 1;
  localparam logic [WAIT_COUNT_BITS-1:0] WAIT_RESET =
    WAIT_COUNT_BITS'(msls_pkg::WAIT_RESET_TICKS);

  logic [WAIT_COUNT_BITS-1:0] start_wait_ticks;
  msls_pkg::state_t           state;
  logic [CW-1:0]              act_count;
  msls_pkg::step_t            step;
  logic [CW-1:0]              act_count_next;

  logic       s1_valid;
  logic       s1_emergency;
  logic       s1_ready;
  logic [2:0] s1_kind;
  logic       advance;

  logic       out_valid;
  logic       out_drive_enable;
  logic [2:0] out_level;
  logic       out_active;

  assign advance = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_wait_ticks <= WAIT_RESET;
    end else if (cfg_wr_en) begin
      start_wait_ticks <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_emergency <= s_axis_tdata[0];
      s1_ready <= s_axis_tdata[1];
      s1_kind <= s_axis_tuser;
    end
  end

  msls_next #(
    .WAIT_COUNT_BITS(WAIT_COUNT_BITS)
  ) u_next (
    .cur          (state),
    .count        (act_count),
    .wait_ticks   (start_wait_ticks),
    .emergency_in (s1_emergency),
    .drive_ready  (s1_ready),
    .kind         (s1_kind),
    .nxt          (step),
    .count_next   (act_count_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.level <= msls_pkg::LV_OFF;
      state.running <= 1'b0;
      act_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        state <= step.state;
        act_count <= act_count_next;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_drive_enable <= step.drive_enable;
      out_level <= msls_pkg::level_code(step.state.level);
      out_active <= step.state.running;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {3'b000, out_active, out_level, out_drive_enable};

`ifndef SYNTH
  a_count_only_starting: assert property (@(posedge clk) disable iff (rst)
    (state.level != msls_pkg::LV_STARTING) |-> (act_count == '0))
    else $error("activation count nonzero outside starting level");

  a_enable_matches_level: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[0] ==
      ((m_axis_tdata[3:1] == msls_pkg::LVC_POWER_ON) ||
       (m_axis_tdata[3:1] == msls_pkg::LVC_MOVING))))
    else $error("drive enable disagrees with level");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !advance)
    else $error("state advanced while result stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_axis_tvalid)
    else $error("result register not loaded after advance");
`endif

endmodule

`default_nettype wire

// ===== design/msls_next.sv =====
// Next-state logic for one safety tick: level transition, counter, run flag.
// Depends on msls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msls_next #(
  parameter int WAIT_COUNT_BITS = msls_pkg::WAIT_COUNT_BITS_DEFAULT
) (
  input  var msls_pkg::state_t         cur,
  input  var logic [WAIT_COUNT_BITS:0] count,
  input  var logic [WAIT_COUNT_BITS-1:0] wait_ticks,
  input  var logic                     emergency_in,
  input  var logic                     drive_ready,
  input  var logic [2:0]               kind,
  output msls_pkg::step_t              nxt,
  output logic [WAIT_COUNT_BITS:0]     count_next
);

  localparam int CW = WAIT_COUNT_BITS + 1;

  msls_pkg::level_t lv;
  msls_pkg::level_t lv_next;
  logic             running_next;
  logic             in_mid;
  logic             trip;
  logic             abort_hit;
  logic             cmd_hit;
  msls_pkg::level_t cmd_level;
  logic [CW-1:0]    count_inc;
  logic [CW-1:0]    count_rule;

  always_comb begin
    lv = cur.level;
    in_mid = (lv != msls_pkg::LV_OFF) && (lv != msls_pkg::LV_EMERGENCY);
    trip = in_mid && (emergency_in || (lv == msls_pkg::LV_MOVING && !drive_ready));
    abort_hit = (kind == msls_pkg::CMD_ABORT) && (lv != msls_pkg::LV_OFF);

    cmd_hit = 1'b1;
    cmd_level = msls_pkg::LV_OFF;
    priority if (kind == msls_pkg::CMD_SWITCH_ON && lv == msls_pkg::LV_OFF) begin
      cmd_level = msls_pkg::LV_ON;
    end else if (kind == msls_pkg::CMD_SWITCH_OFF && lv == msls_pkg::LV_ON) begin
      cmd_level = msls_pkg::LV_OFF;
    end else if (kind == msls_pkg::CMD_STOP_MOVING && lv == msls_pkg::LV_MOVING) begin
      cmd_level = msls_pkg::LV_POWER_ON;
    end else if (kind == msls_pkg::CMD_FORCE_EMERGENCY && in_mid) begin
      cmd_level = msls_pkg::LV_EMERGENCY;
    end else begin
      cmd_hit = 1'b0;
    end

    count_inc = (count == {CW{1'b1}}) ? count : count + CW'(1);

    lv_next = lv;
    running_next = cur.running;
    count_rule = count;
    priority if (trip) begin
      lv_next = msls_pkg::LV_EMERGENCY;
    end else if (abort_hit) begin
      lv_next = msls_pkg::LV_STOPPING;
    end else if (cmd_hit) begin
      lv_next = cmd_level;
    end else begin
      unique case (lv)
        msls_pkg::LV_EMERGENCY: begin
          if (!emergency_in) lv_next = msls_pkg::LV_ON;
        end
        msls_pkg::LV_ON: begin
          running_next = 1'b0;
          lv_next = msls_pkg::LV_STARTING;
        end
        msls_pkg::LV_STARTING: begin
          running_next = 1'b1;
          count_rule = count_inc;
          if (count_inc > {1'b0, wait_ticks}) lv_next = msls_pkg::LV_POWER_ON;
        end
        msls_pkg::LV_STOPPING: begin
          running_next = 1'b0;
          lv_next = msls_pkg::LV_OFF;
        end
        msls_pkg::LV_POWER_ON: begin
          if (drive_ready) lv_next = msls_pkg::LV_MOVING;
        end
        default: begin
          lv_next = lv;
        end
      endcase
    end

    count_next = (lv_next != lv) ? '0 : count_rule;
    nxt.state.level = lv_next;
    nxt.state.running = running_next;
    nxt.drive_enable = (lv_next == msls_pkg::LV_POWER_ON) || (lv_next == msls_pkg::LV_MOVING);
  end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for motor_safety_level_supervisor: directed ticks, then random phases.
// Depends on msls_pkg and the design files; expects each result from the directed table or a local level model.
`timescale 1ns / 1ps

module testbench;

  localparam int WBITS = msls_pkg::WAIT_COUNT_BITS_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 13;
  localparam int TICKS_PER_PHASE = 150;
  localparam int HOLD_AT_RESULT = 900;
  localparam int HOLD_CYCLES = 80;
  localparam logic [WBITS:0] COUNT_MAX = '1;

  typedef struct packed {
    logic       control_active;
    logic [2:0] level_now;
    logic       drive_enable;
  } result_t;

  typedef struct packed {
    logic             cfg;
    logic [WBITS-1:0] wait_val;
    logic             emerg;
    logic             ready;
    logic [2:0]       kind;
    logic             typed;
    logic [2:0]       lvl;
    logic             de;
    logic             run;
  } tick_row_t;

  localparam int NROWS = 29;

  logic             clk;
  logic             rst;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;
  logic [2:0]       s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [7:0]       m_axis_tdata;
  logic             cfg_wr_en;
  logic [WBITS-1:0] cfg_wr_data;

  // predictor state
  logic [2:0]       level_q;
  logic [WBITS:0]   activation_q;
  logic             running_q;
  logic [WBITS-1:0] start_wait_q;

  result_t pending_results[$];
  int      errors;
  int      ticks_sent;
  int      results_seen;
  int      cfg_writes;
  int      cycles;
  bit      tx_quiet;
  bit      rx_quiet;
  logic [6:0] levels_seen;

  tick_row_t directed_ticks [NROWS] = '{
    '{1'b0, 20'd0, 1'b0, 1'b0, msls_pkg::CMD_NONE, 1'b1, msls_pkg::LVC_OFF, 1'b0, 1'b0},
    '{1'b0, 20'd0, 1'b1, 1'b1, 3'd7, 1'b1, msls_pkg::LVC_OFF, 1'b0, 1'b0},
    '{1'b0, 20'd0, 1'b0, 1'b1, msls_pkg::CMD_ABORT, 1'b1, msls_pkg::LVC_OFF, 1'b0, 1'b0},
    '{1'b0, 20'd0, 1'b1, 1'b0, msls_pkg::CMD_FORCE_EMERGENCY,
      1'b1, msls_pkg::LVC_OFF, 1'b0, 1'b0},
    '{1'b0, 20'd0, 1'b0, 1'b0, msls_pkg::CMD_SWITCH_ON, 1'b1, msls_pkg::LVC_ON, 1'b0, 1'b0},
    '{1'b0, 20'd0, 1'b0, 1'b0, msls_pkg::CMD_SWITCH_OFF, 1'b1, msls_pkg::LVC_OFF, 1'b0, 1'b0},
    '{1'b0, 20'd0, 1'b0, 1'b1, msls_pkg::CMD_SWITCH_ON, 1'b1, msls_pkg::LVC_ON, 1'b0, 1'b0},
    '{1'b0, 20'd0, 1'b0, 1'b1, msls_pkg::CMD_NONE, 1'b1, msls_pkg::LVC_STARTING, 1'b0, 1'b0},
    '{1'b0, 20'd0, 1'b0, 1'b1, 3'd6, 1'b1, msls_pkg::LVC_STARTING, 1'b0, 1'b1},
    '{1'b0, 20'd0, 1'b0, 1'b1, msls_pkg::CMD_ABORT, 1'b1, msls_pkg::LVC_STOPPING, 1'b0, 1'b1},
    '{1'b0, 20'd0, 1'b0, 1'b1, msls_pkg::CMD_NONE, 1'b1, msls_pkg::LVC_OFF, 1'b0, 1'b0},
    '{1'b0, 20'd0, 1'b0, 1'b1, msls_pkg::CMD_SWITCH_ON, 1'b1, msls_pkg::LVC_ON, 1'b0, 1'b0},
    '{1'b0, 20'd0, 1'b1, 1'b1, msls_pkg::CMD_NONE, 1'b1, msls_pkg::LVC_EMERGENCY, 1'b0, 1'b0},
    '{1'b0, 20'd0, 1'b1, 1'b1, msls_pkg::CMD_NONE, 1'b1, msls_pkg::LVC_EMERGENCY, 1'b0, 1'b0},
    '{1'b0, 20'd0, 1'b0, 1'b1, msls_pkg::CMD_SWITCH_OFF, 1'b1, msls_pkg::LVC_ON, 1'b0, 1'b0},
    '{1'b0, 20'd0, 1'b0, 1'b1, msls_pkg::CMD_FORCE_EMERGENCY,
      1'b1, msls_pkg::LVC_EMERGENCY, 1'b0, 1'b0},
    '{1'b0, 20'd0, 1'b1, 1'b1, msls_pkg::CMD_ABORT, 1'b1, msls_pkg::LVC_STOPPING, 1'b0, 1'b0},
    '{1'b0, 20'd0, 1'b0, 1'b1, msls_pkg::CMD_SWITCH_ON, 1'b1, msls_pkg::LVC_OFF, 1'b0, 1'b0},
    '{1'b1, 20'd0, 1'b0, 1'b0, msls_pkg::CMD_NONE, 1'b0, msls_pkg::LVC_OFF, 1'b0, 1'b0},
    '{1'b0, 20'd0, 1'b0, 1'b1, msls_pkg::CMD_SWITCH_ON, 1'b0, msls_pkg::LVC_OFF, 1'b0, 1'b0},
    '{1'b0, 20'd0, 1'b0, 1'b1, msls_pkg::CMD_NONE, 1'b0, msls_pkg::LVC_OFF, 1'b0, 1'b0},
    '{1'b0, 20'd0, 1'b0, 1'b0, msls_pkg::CMD_NONE, 1'b0, msls_pkg::LVC_OFF, 1'b0, 1'b0},
    '{1'b0, 20'd0, 1'b0, 1'b0, msls_pkg::CMD_NONE, 1'b0, msls_pkg::LVC_OFF, 1'b0, 1'b0},
    '{1'b0, 20'd0, 1'b0, 1'b1, msls_pkg::CMD_NONE, 1'b0, msls_pkg::LVC_OFF, 1'b0, 1'b0},
    '{1'b0, 20'd0, 1'b0, 1'b1, msls_pkg::CMD_STOP_MOVING, 1'b0, msls_pkg::LVC_OFF, 1'b0, 1'b0},
    '{1'b0, 20'd0, 1'b0, 1'b1, msls_pkg::CMD_NONE, 1'b0, msls_pkg::LVC_OFF, 1'b0, 1'b0},
    '{1'b0, 20'd0, 1'b0, 1'b0, msls_pkg::CMD_NONE, 1'b0, msls_pkg::LVC_OFF, 1'b0, 1'b0},
    '{1'b1, 20'hFFFFF, 1'b0, 1'b0, msls_pkg::CMD_NONE, 1'b0, msls_pkg::LVC_OFF, 1'b0, 1'b0},
    '{1'b0, 20'd0, 1'b0, 1'b1, msls_pkg::CMD_NONE, 1'b0, msls_pkg::LVC_OFF, 1'b0, 1'b0}
  };

  motor_safety_level_supervisor u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic result_t advance_safety_level(input logic emerg, input logic ready,
                                                   input logic [2:0] kind);
    logic [2:0] cur;
    logic [2:0] nxt;
    logic       taken;
    result_t    r;
    cur = (level_q > msls_pkg::LVC_MOVING) ? msls_pkg::LVC_OFF : level_q;
    nxt = cur;
    taken = 1'b0;
    if (cur >= msls_pkg::LVC_ON && (emerg || (cur == msls_pkg::LVC_MOVING && !ready))) begin
      nxt = msls_pkg::LVC_EMERGENCY;
      taken = 1'b1;
    end
    if (!taken && kind == msls_pkg::CMD_ABORT && cur != msls_pkg::LVC_OFF) begin
      nxt = msls_pkg::LVC_STOPPING;
      taken = 1'b1;
    end
    if (!taken) begin
      if (kind == msls_pkg::CMD_SWITCH_ON && cur == msls_pkg::LVC_OFF) begin
        nxt = msls_pkg::LVC_ON;
        taken = 1'b1;
      end else if (kind == msls_pkg::CMD_SWITCH_OFF && cur == msls_pkg::LVC_ON) begin
        nxt = msls_pkg::LVC_OFF;
        taken = 1'b1;
      end else if (kind == msls_pkg::CMD_STOP_MOVING && cur == msls_pkg::LVC_MOVING) begin
        nxt = msls_pkg::LVC_POWER_ON;
        taken = 1'b1;
      end else if (kind == msls_pkg::CMD_FORCE_EMERGENCY && cur >= msls_pkg::LVC_ON) begin
        nxt = msls_pkg::LVC_EMERGENCY;
        taken = 1'b1;
      end
    end
    if (!taken) begin
      case (cur)
        msls_pkg::LVC_EMERGENCY: begin
          if (!emerg) nxt = msls_pkg::LVC_ON;
        end
        msls_pkg::LVC_ON: begin
          running_q = 1'b0;
          nxt = msls_pkg::LVC_STARTING;
        end
        msls_pkg::LVC_STARTING: begin
          running_q = 1'b1;
          if (activation_q != COUNT_MAX) activation_q = activation_q + 1'b1;
          if (activation_q > {1'b0, start_wait_q}) nxt = msls_pkg::LVC_POWER_ON;
        end
        msls_pkg::LVC_STOPPING: begin
          running_q = 1'b0;
          nxt = msls_pkg::LVC_OFF;
        end
        msls_pkg::LVC_POWER_ON: begin
          if (ready) nxt = msls_pkg::LVC_MOVING;
        end
        default: ;
      endcase
    end
    if (nxt != cur) activation_q = '0;
    level_q = nxt;
    r.drive_enable = (nxt == msls_pkg::LVC_POWER_ON || nxt == msls_pkg::LVC_MOVING);
    r.level_now = nxt;
    r.control_active = running_q;
    return r;
  endfunction

  task automatic send_tick(input logic emerg, input logic ready, input logic [2:0] kind,
                           input logic typed, input result_t typed_res);
    int      gap;
    result_t predicted;
    gap = tx_quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, ready, emerg};
    s_axis_tuser <= kind;
    do @(posedge clk); while (!s_axis_tready);
    predicted = advance_safety_level(emerg, ready, kind);
    pending_results.push_back(typed ? typed_res : predicted);
    ticks_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_start_wait(input logic [WBITS-1:0] value);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    start_wait_q = value;
    cfg_writes++;
  endtask

  // result side: random stall, one long hold to back up the input
  initial begin
    int      stall;
    result_t got;
    result_t want;
    do @(posedge clk); while (rst);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 4);
      if (results_seen == HOLD_AT_RESULT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      got = m_axis_tdata[4:0];
      results_seen++;
      if (got.level_now <= msls_pkg::LVC_MOVING) levels_seen[got.level_now] = 1'b1;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        if (got.drive_enable !== want.drive_enable) begin
          errors++;
          $display("%0t: drive_enable expected %b actual %b", $time,
                   want.drive_enable, got.drive_enable);
        end
        if (got.level_now !== want.level_now) begin
          errors++;
          $display("%0t: level_now expected %0d actual %0d", $time,
                   want.level_now, got.level_now);
        end
        if (got.control_active !== want.control_active) begin
          errors++;
          $display("%0t: control_active expected %b actual %b", $time,
                   want.control_active, got.control_active);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    logic [2:0]       kind;
    logic             emerg;
    logic             ready;
    logic [WBITS-1:0] wval;
    int               roll;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    errors = 0;
    ticks_sent = 0;
    results_seen = 0;
    cfg_writes = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    levels_seen = '0;
    level_q = msls_pkg::LVC_OFF;
    activation_q = '0;
    running_q = 1'b0;
    start_wait_q = WBITS'(msls_pkg::WAIT_RESET_TICKS);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_ticks[i]) begin
      if (directed_ticks[i].cfg) begin
        write_start_wait(directed_ticks[i].wait_val);
      end else begin
        send_tick(directed_ticks[i].emerg, directed_ticks[i].ready, directed_ticks[i].kind,
                  directed_ticks[i].typed,
                  '{directed_ticks[i].run, directed_ticks[i].lvl, directed_ticks[i].de});
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: wval = '1;
        1: wval = '0;
        2: wval = WBITS'(1);
        default: wval = ($urandom_range(0, 5) == 0) ? WBITS'($urandom_range(13, 300))
                                                    : WBITS'($urandom_range(0, 12));
      endcase
      write_start_wait(wval);
      tx_quiet = (p % 4 == 1);
      rx_quiet = (p % 4 == 2);
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        if (p % 3 == 2) begin
          emerg = 1'($urandom_range(0, 1));
          ready = 1'($urandom_range(0, 1));
          kind = 3'($urandom_range(0, 7));
        end else begin
          emerg = ($urandom_range(0, 40) == 0);
          ready = ($urandom_range(0, 9) != 0);
          roll = $urandom_range(0, 99);
          if (roll < 60) kind = msls_pkg::CMD_NONE;
          else if (roll < 70) kind = msls_pkg::CMD_SWITCH_ON;
          else if (roll < 74) kind = msls_pkg::CMD_SWITCH_OFF;
          else if (roll < 80) kind = msls_pkg::CMD_STOP_MOVING;
          else if (roll < 85) kind = msls_pkg::CMD_ABORT;
          else if (roll < 89) kind = msls_pkg::CMD_FORCE_EMERGENCY;
          else kind = 3'($urandom_range(0, 7));
        end
        send_tick(emerg, ready, kind, 1'b0, '0);
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("covered %0d ticks, %0d results, %0d start wait writes, levels seen %b",
             ticks_sent, results_seen, cfg_writes, levels_seen);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/msls_pkg.sv
design/msls_next.sv
design/motor_safety_level_supervisor.sv
sim/testbench.sv
